[sv/sailboat_dynamics_step_assert.svh]
// Assertion macros used by the checker file.
`ifndef SAILBOAT_DYNAMICS_STEP_ASSERT_SVH
`define SAILBOAT_DYNAMICS_STEP_ASSERT_SVH

// Antecedent this cycle, consequent next cycle, off while in reset.
`define SDS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sailboat step check failed");

// Antecedent and consequent in the same cycle, off while in reset.
`define SDS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sailboat step check failed");

// Next-cycle check that also runs during reset.
`define SDS_ASSERT_ALWAYS(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("sailboat step check failed");

`endif

[sv/sds_pkg.sv]
package sds_pkg;

    // CORDIC arctangent table, Q2.30
    localparam int TABLE_LEN = 24;
    localparam int IDX_W     = 5;
    localparam logic [29:0] ATAN_Q30 [TABLE_LEN] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
        30'd33543515,  30'd16775851,  30'd8388437,   30'd4194283,   30'd2097149,
        30'd1048576,   30'd524288,    30'd262144,    30'd131072,    30'd65536,
        30'd32768,     30'd16384,     30'd8192,      30'd4096,      30'd2048,
        30'd1024,      30'd512,       30'd256,       30'd128
    };

    // Angle constants, Q16.16
    localparam logic signed [33:0] Q_HALF_PI = 34'sd102944;
    localparam logic signed [33:0] Q_PI      = 34'sd205887;
    localparam logic signed [33:0] Q_TWO_PI  = 34'sd411775;

    // CORDIC gain compensation
    localparam logic signed [35:0] GAIN_Q30 = 36'sd652032874;
    localparam logic signed [32:0] GAIN_Q16 = 33'sd39797;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_SAIL_LIFT_GAIN     = 3'd0,
        CFG_RUDDER_LIFT_GAIN   = 3'd1,
        CFG_DRIFT_GAIN         = 3'd2,
        CFG_ANGULAR_DRAG       = 3'd3,
        CFG_LINEAR_DRAG        = 3'd4,
        CFG_INVERSE_INERTIA    = 3'd5,
        CFG_INVERSE_MASS       = 3'd6,
        CFG_SAIL_EFFORT_OFFSET = 3'd7
    } t_cfg_idx;

    // Micro-operations of the shared unit
    typedef enum logic [2:0] {
        OP_MUL  = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_SIN  = 3'd3,
        OP_VEC  = 3'd4,
        OP_SAIL = 3'd5
    } t_op;

    // Sequencer states
    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_ISSUE = 9'b000000010,
        S_MUL   = 9'b000000100,
        S_WB    = 9'b000001000,
        S_RED   = 9'b000010000,
        S_FOLD  = 9'b000100000,
        S_CORD  = 9'b001000000,
        S_CFIN  = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    // Saturate a sum to 32 bits signed
    function automatic logic signed [31:0] sat36(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > 36'sd2147483647) r = 32'sh7FFFFFFF;
        else if (v < -36'sd2147483648) r = 32'sh80000000;
        else r = v[31:0];
        return r;
    endfunction

    // Saturate a shifted product to 32 bits signed
    function automatic logic signed [31:0] sat53(input logic signed [52:0] v);
        logic signed [31:0] r;
        if (v > 53'sd2147483647) r = 32'sh7FFFFFFF;
        else if (v < -53'sd2147483648) r = 32'sh80000000;
        else r = v[31:0];
        return r;
    endfunction

endpackage

[sv/sailboat_dynamics_step.sv]
// Channel  | Direction | Handshake                  | Payload
// cfg      | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
// in       | in        | i_in_valid / o_in_ready    | rudder, sheet rate, wind, step length
// out      | out       | o_out_valid / i_out_ready  | pos, heading, speed, turn, sail, sheet
// The sequencer runs 29 multiplies and nine sine/cosine evaluations (each a modulo 2*pi
// reduction plus the CORDIC iterations) and one vectoring pass on a single shared
// multiplier, adder and CORDIC.
// Reset is synchronous and active low; sequencer, boat state, configuration and output valid return to their defaults.
// A result held by a stalled output does not block the next input transfer.
module sailboat_dynamics_step
    import sds_pkg::*;
#(
    parameter int MAST_OFFSET   = 65536,
    parameter int RUDDER_OFFSET = 131072,
    parameter int CORDIC_STEPS  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [17:0] i_rudder_angle,
    input  logic signed [17:0] i_sheet_rate,
    input  logic [30:0]        i_wind_speed,
    input  logic signed [19:0] i_wind_heading,
    input  logic [16:0]        i_step_length,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_heading,
    output logic signed [31:0] o_speed,
    output logic signed [31:0] o_turn_rate,
    output logic signed [31:0] o_sail_position,
    output logic signed [31:0] o_sheet_out
);

    localparam int NSTEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(NSTEPS - 1);
    localparam logic [5:0] PC_LAST = 6'd53;

    // Sequencer
    t_state r_state;
    logic [5:0] r_pc;

    // Configuration
    logic [30:0] r_sail_gain, r_rudder_gain, r_drift_gain, r_ang_drag, r_lin_drag;
    logic [30:0] r_inv_inertia, r_inv_mass;
    logic signed [31:0] r_seo;

    // Boat state
    logic signed [31:0] r_x, r_y, r_hd, r_spd, r_tr, r_sheet, r_sail;

    // Latched input item
    logic signed [17:0] r_rud, r_rate;
    logic [30:0] r_ws;
    logic signed [19:0] r_wd;
    logic [16:0] r_dt;

    // Intermediates
    logic signed [31:0] r_tmp, r_tmp2, r_awx, r_awy, r_awd, r_aws, r_drift, r_dx, r_dy;
    logic signed [31:0] r_fr, r_fs, r_torque, r_thrust;
    logic signed [18:0] r_rc, r_rs, r_ac, r_shc, r_ns, r_hc, r_hs, r_wc, r_wsn;
    logic signed [18:0] r_rudc, r_ruds, r_sds, r_sc, r_ss;

    // Shared multiplier
    logic signed [35:0] r_ua;
    logic signed [32:0] r_ub;
    logic signed [68:0] r_prod;

    // Angle reduction and CORDIC
    logic [33:0] r_red;
    logic r_aneg;
    logic [3:0] r_k;
    logic signed [35:0] r_cx, r_cy, r_cz;
    logic [IDX_W-1:0] r_i;
    logic r_vmode, r_sneg;

    // Output register
    logic r_ovalid;
    logic signed [31:0] r_o_x, r_o_y, r_o_hd, r_o_spd, r_o_tr, r_o_sail, r_o_sheet;

    // Decoded operation
    t_op op;
    logic signed [35:0] op_a;
    logic signed [32:0] op_b;
    logic signed [33:0] op_ang;
    logic sheet_in_range;

    // Writeback
    logic w_we;
    logic signed [31:0] w_r1, w_r2;
    logic pc_last, out_free;

    assign sheet_in_range = (34'(r_sheet) > -Q_HALF_PI) && (34'(r_sheet) < Q_HALF_PI);
    assign pc_last  = (r_pc == PC_LAST);
    assign out_free = !r_ovalid || i_out_ready;

    // Step program: operation and operands per program step
    always_comb begin
        op     = OP_ADD;
        op_a   = '0;
        op_b   = '0;
        op_ang = '0;
        case (r_pc)
            6'd0: begin op = OP_MUL; op_a = 36'(r_dt); op_b = 33'(r_rate); end
            6'd1: begin
                op = OP_ADD; op_a = 36'(r_sheet);
                op_b = sheet_in_range ? 33'(r_tmp) : '0;
            end
            6'd2: begin op = OP_SIN; op_ang = 34'(r_wd) - 34'(r_hd); end
            6'd3: begin op = OP_MUL; op_a = 36'(r_ws); op_b = 33'(r_rc); end
            6'd4: begin op = OP_SUB; op_a = 36'(r_tmp); op_b = 33'(r_spd); end
            6'd5: begin op = OP_MUL; op_a = 36'(r_ws); op_b = 33'(r_rs); end
            6'd6: begin op = OP_VEC; op_a = 36'(r_awx); op_b = 33'(r_awy); end
            6'd7: begin op = OP_SIN; op_ang = 34'(r_awd); end
            6'd8: begin op = OP_SIN; op_ang = 34'(r_sheet); end
            6'd9: begin op = OP_SIN; op_ang = -34'(r_awd); end
            6'd10: op = OP_SAIL;
            6'd11: begin op = OP_SIN; op_ang = 34'(r_hd); end
            6'd12: begin op = OP_SIN; op_ang = 34'(r_wd); end
            6'd13: begin op = OP_MUL; op_a = 36'(r_drift_gain); op_b = 33'(r_ws); end
            6'd14: begin op = OP_MUL; op_a = 36'(r_spd); op_b = 33'(r_hc); end
            6'd15: begin op = OP_MUL; op_a = 36'(r_drift); op_b = 33'(r_wc); end
            6'd16: begin op = OP_ADD; op_a = 36'(r_tmp); op_b = 33'(r_tmp2); end
            6'd17: begin op = OP_MUL; op_a = 36'(r_spd); op_b = 33'(r_hs); end
            6'd18: begin op = OP_MUL; op_a = 36'(r_drift); op_b = 33'(r_wsn); end
            6'd19: begin op = OP_ADD; op_a = 36'(r_tmp); op_b = 33'(r_tmp2); end
            6'd20: begin op = OP_MUL; op_a = 36'(r_dx); op_b = 33'(r_dt); end
            6'd21: begin op = OP_ADD; op_a = 36'(r_x); op_b = 33'(r_tmp); end
            6'd22: begin op = OP_MUL; op_a = 36'(r_dy); op_b = 33'(r_dt); end
            6'd23: begin op = OP_ADD; op_a = 36'(r_y); op_b = 33'(r_tmp); end
            6'd24: begin op = OP_SIN; op_ang = 34'(r_rud); end
            6'd25: begin op = OP_MUL; op_a = 36'(r_rudder_gain); op_b = 33'(r_spd); end
            6'd26: begin op = OP_MUL; op_a = 36'(r_tmp); op_b = 33'(r_ruds); end
            6'd27: begin op = OP_SIN; op_ang = 34'(r_sail) - 34'(r_awd); end
            6'd28: begin op = OP_MUL; op_a = 36'(r_sail_gain); op_b = 33'(r_aws); end
            6'd29: begin op = OP_MUL; op_a = 36'(r_tmp); op_b = 33'(r_sds); end
            6'd30: begin op = OP_SIN; op_ang = 34'(r_sail); end
            6'd31: begin op = OP_MUL; op_a = 36'(MAST_OFFSET); op_b = 33'(r_sc); end
            6'd32: begin op = OP_SUB; op_a = 36'(r_seo); op_b = 33'(r_tmp); end
            6'd33: begin op = OP_MUL; op_a = 36'(r_tmp); op_b = 33'(r_fs); end
            6'd34: begin op = OP_MUL; op_a = 36'(RUDDER_OFFSET); op_b = 33'(r_rudc); end
            6'd35: begin op = OP_MUL; op_a = 36'(r_tmp2); op_b = 33'(r_fr); end
            6'd36: begin op = OP_SUB; op_a = 36'(r_tmp); op_b = 33'(r_tmp2); end
            6'd37: begin op = OP_MUL; op_a = 36'(r_ang_drag); op_b = 33'(r_tr); end
            6'd38: begin op = OP_MUL; op_a = 36'(r_tmp2); op_b = 33'(r_spd); end
            6'd39: begin op = OP_SUB; op_a = 36'(r_tmp); op_b = 33'(r_tmp2); end
            6'd40: begin op = OP_MUL; op_a = 36'(r_ss); op_b = 33'(r_fs); end
            6'd41: begin op = OP_MUL; op_a = 36'(r_ruds); op_b = 33'(r_fr); end
            6'd42: begin op = OP_SUB; op_a = 36'(r_tmp); op_b = 33'(r_tmp2); end
            6'd43: begin op = OP_MUL; op_a = 36'(r_lin_drag); op_b = 33'(r_spd); end
            6'd44: begin op = OP_MUL; op_a = 36'(r_tmp2); op_b = 33'(r_spd); end
            6'd45: begin op = OP_SUB; op_a = 36'(r_tmp); op_b = 33'(r_tmp2); end
            6'd46: begin op = OP_MUL; op_a = 36'(r_torque); op_b = 33'(r_inv_inertia); end
            6'd47: begin op = OP_MUL; op_a = 36'(r_tmp); op_b = 33'(r_dt); end
            6'd48: begin op = OP_ADD; op_a = 36'(r_tr); op_b = 33'(r_tmp); end
            6'd49: begin op = OP_MUL; op_a = 36'(r_thrust); op_b = 33'(r_inv_mass); end
            6'd50: begin op = OP_MUL; op_a = 36'(r_tmp); op_b = 33'(r_dt); end
            6'd51: begin op = OP_ADD; op_a = 36'(r_spd); op_b = 33'(r_tmp); end
            6'd52: begin op = OP_MUL; op_a = 36'(r_tr); op_b = 33'(r_dt); end
            6'd53: begin op = OP_ADD; op_a = 36'(r_hd); op_b = 33'(r_tmp); end
            default: op = OP_ADD;
        endcase
    end

    // Sail set: tight sheet follows folded apparent wind, loose sits leeward
    logic signed [35:0] sail_sum;
    logic signed [31:0] sail_fold, sail_new, sheet_new;
    always_comb begin
        sail_sum = 36'(r_ac) + 36'(r_shc);
        if (r_awd > 32'(Q_HALF_PI)) sail_fold = r_awd - 32'(Q_PI);
        else if (r_awd < -32'(Q_HALF_PI)) sail_fold = r_awd + 32'(Q_PI);
        else sail_fold = r_awd;
        if (sail_sum < 0) begin
            sail_new  = sail_fold;
            sheet_new = (sail_fold == 0) ? '0 : r_sheet;
        end else begin
            sheet_new = r_sheet;
            if (r_ns > 0) sail_new = r_sheet;
            else if (r_sheet == 32'sh80000000) sail_new = 32'sh7FFFFFFF;
            else sail_new = -r_sheet;
        end
    end

    // Range fold of the reduced angle into [-pi/2, pi/2]
    logic signed [20:0] red_r, red_p, red_h;
    logic red_neg;
    always_comb begin
        red_r = r_aneg ? -21'(r_red) : 21'(r_red);
        if (red_r > 21'(Q_PI)) red_p = red_r - 21'(Q_TWO_PI);
        else if (red_r < -21'(Q_PI)) red_p = red_r + 21'(Q_TWO_PI);
        else red_p = red_r;
        red_neg = 1'b1;
        if (red_p > 21'(Q_HALF_PI)) red_h = red_p - 21'(Q_PI);
        else if (red_p < -21'(Q_HALF_PI)) red_h = red_p + 21'(Q_PI);
        else begin
            red_h   = red_p;
            red_neg = 1'b0;
        end
    end

    // CORDIC micro-rotation
    logic signed [35:0] cx_sh, cy_sh, c_at, n_cx, n_cy, n_cz;
    logic c_rot;
    always_comb begin
        cx_sh = r_cx >>> r_i;
        cy_sh = r_cy >>> r_i;
        c_at  = 36'(ATAN_Q30[r_i]);
        c_rot = r_vmode ? (r_cy < 0) : (r_cz >= 0);
        if (c_rot) begin
            n_cx = r_cx - cy_sh;
            n_cy = r_cy + cx_sh;
            n_cz = r_cz - c_at;
        end else begin
            n_cx = r_cx + cy_sh;
            n_cy = r_cy - cx_sh;
            n_cz = r_cz + c_at;
        end
    end

    // Reduction compare/subtract
    logic [33:0] red_div;
    assign red_div = 34'(Q_TWO_PI) << r_k;

    // Writeback value selection
    logic signed [35:0] sum36, cos36, sin36;
    always_comb begin
        sum36 = (op == OP_SUB) ? (op_a - 36'(op_b)) : (op_a + 36'(op_b));
        cos36 = r_sneg ? -(r_cx >>> 14) : (r_cx >>> 14);
        sin36 = r_sneg ? -(r_cy >>> 14) : (r_cy >>> 14);
        w_we = 1'b0;
        w_r1 = '0;
        w_r2 = '0;
        case (r_state)
            S_ISSUE: begin
                case (op)
                    OP_ADD, OP_SUB: begin
                        w_we = 1'b1;
                        w_r1 = sat36(sum36);
                    end
                    OP_SAIL: begin
                        w_we = 1'b1;
                        w_r1 = sail_new;
                        w_r2 = sheet_new;
                    end
                    OP_VEC: begin
                        // wind along the x axis: direction 0 or pi, speed |x|
                        w_we = (op_b == 0);
                        w_r1 = (op_a < 0) ? 32'(Q_PI) : '0;
                        w_r2 = sat36((op_a < 0) ? -op_a : op_a);
                    end
                    default: w_we = 1'b0;
                endcase
            end
            S_WB: begin
                w_we = 1'b1;
                w_r1 = sat53(r_prod[68:16]);
            end
            S_CFIN: begin
                w_we = 1'b1;
                w_r1 = r_vmode ? 32'(r_cz >>> 14) : 32'(cos36);
                w_r2 = 32'(sin36);
            end
            default: w_we = 1'b0;
        endcase
    end

    // Register file writeback
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x     <= '0;
            r_y     <= '0;
            r_hd    <= '0;
            r_spd   <= '0;
            r_tr    <= '0;
            r_sheet <= '0;
            r_sail  <= '0;
        end else if (w_we) begin
            case (r_pc)
                6'd0:  r_tmp <= w_r1;
                6'd1:  r_sheet <= w_r1;
                6'd2:  begin r_rc <= 19'(w_r1); r_rs <= 19'(w_r2); end
                6'd3:  r_tmp <= w_r1;
                6'd4:  r_awx <= w_r1;
                6'd5:  r_awy <= w_r1;
                6'd6: begin
                    // vectoring: angle first, magnitude after the gain multiply
                    if (r_state == S_WB) begin
                        r_aws <= w_r1;
                    end else begin
                        r_awd <= w_r1;
                        r_aws <= w_r2;
                    end
                end
                6'd7:  r_ac <= 19'(w_r1);
                6'd8:  r_shc <= 19'(w_r1);
                6'd9:  r_ns <= 19'(w_r2);
                6'd10: begin r_sail <= w_r1; r_sheet <= w_r2; end
                6'd11: begin r_hc <= 19'(w_r1); r_hs <= 19'(w_r2); end
                6'd12: begin r_wc <= 19'(w_r1); r_wsn <= 19'(w_r2); end
                6'd13: r_drift <= w_r1;
                6'd14, 6'd17, 6'd20, 6'd22, 6'd25, 6'd28, 6'd31, 6'd32, 6'd33,
                6'd36, 6'd40, 6'd42, 6'd46, 6'd47, 6'd49, 6'd50, 6'd52: r_tmp <= w_r1;
                6'd15, 6'd18, 6'd34, 6'd35, 6'd37, 6'd38, 6'd41, 6'd43, 6'd44:
                    r_tmp2 <= w_r1;
                6'd16: r_dx <= w_r1;
                6'd19: r_dy <= w_r1;
                6'd21: r_x <= w_r1;
                6'd23: r_y <= w_r1;
                6'd24: begin r_rudc <= 19'(w_r1); r_ruds <= 19'(w_r2); end
                6'd26: r_fr <= w_r1;
                6'd27: r_sds <= 19'(w_r2);
                6'd29: r_fs <= w_r1;
                6'd30: begin r_sc <= 19'(w_r1); r_ss <= 19'(w_r2); end
                6'd39: r_torque <= w_r1;
                6'd45: r_thrust <= w_r1;
                6'd48: r_tr <= w_r1;
                6'd51: r_spd <= w_r1;
                6'd53: r_hd <= w_r1;
                default: r_tmp <= r_tmp;
            endcase
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sail_gain   <= 31'd65536;
            r_rudder_gain <= 31'd65536;
            r_drift_gain  <= '0;
            r_ang_drag    <= '0;
            r_lin_drag    <= '0;
            r_inv_inertia <= 31'd65536;
            r_inv_mass    <= 31'd65536;
            r_seo         <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SAIL_LIFT_GAIN:     r_sail_gain   <= i_cfg_data[30:0];
                CFG_RUDDER_LIFT_GAIN:   r_rudder_gain <= i_cfg_data[30:0];
                CFG_DRIFT_GAIN:         r_drift_gain  <= i_cfg_data[30:0];
                CFG_ANGULAR_DRAG:       r_ang_drag    <= i_cfg_data[30:0];
                CFG_LINEAR_DRAG:        r_lin_drag    <= i_cfg_data[30:0];
                CFG_INVERSE_INERTIA:    r_inv_inertia <= i_cfg_data[30:0];
                CFG_INVERSE_MASS:       r_inv_mass    <= i_cfg_data[30:0];
                CFG_SAIL_EFFORT_OFFSET: r_seo         <= i_cfg_data;
                default:                r_seo         <= r_seo;
            endcase
        end
    end

    // Sequencer and shared datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pc     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_out_ready && (r_state != S_OUT)) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_rud   <= i_rudder_angle;
                        r_rate  <= i_sheet_rate;
                        r_ws    <= i_wind_speed;
                        r_wd    <= i_wind_heading;
                        r_dt    <= i_step_length;
                        r_pc    <= '0;
                        r_state <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    case (op)
                        OP_MUL: begin
                            r_ua    <= op_a;
                            r_ub    <= op_b;
                            r_state <= S_MUL;
                        end
                        OP_SIN: begin
                            r_red   <= (op_ang < 0) ? 34'(-op_ang) : 34'(op_ang);
                            r_aneg  <= (op_ang < 0);
                            r_k     <= 4'd14;
                            r_state <= S_RED;
                        end
                        OP_VEC: begin
                            if (op_b == 0) begin
                                r_pc <= r_pc + 6'd1;
                            end else begin
                                r_vmode <= 1'b1;
                                r_i     <= '0;
                                r_state <= S_CORD;
                                if (op_a < 0) begin
                                    r_cx <= -op_a;
                                    r_cy <= -36'(op_b);
                                    r_cz <= (op_b > 0) ? (36'(Q_PI) <<< 14)
                                                       : -(36'(Q_PI) <<< 14);
                                end else begin
                                    r_cx <= op_a;
                                    r_cy <= 36'(op_b);
                                    r_cz <= '0;
                                end
                            end
                        end
                        default: begin
                            if (pc_last) r_state <= S_OUT;
                            else r_pc <= r_pc + 6'd1;
                        end
                    endcase
                end
                S_MUL: begin
                    r_prod  <= r_ua * r_ub;
                    r_state <= S_WB;
                end
                S_WB: begin
                    if (pc_last) begin
                        r_state <= S_OUT;
                    end else begin
                        r_pc    <= r_pc + 6'd1;
                        r_state <= S_ISSUE;
                    end
                end
                S_RED: begin
                    // restoring remainder by 2*pi, one multiple per cycle
                    if (r_red >= red_div) r_red <= r_red - red_div;
                    if (r_k == 4'd0) r_state <= S_FOLD;
                    else r_k <= r_k - 4'd1;
                end
                S_FOLD: begin
                    r_cx    <= GAIN_Q30;
                    r_cy    <= '0;
                    r_cz    <= 36'(red_h) <<< 14;
                    r_sneg  <= red_neg;
                    r_vmode <= 1'b0;
                    r_i     <= '0;
                    r_state <= S_CORD;
                end
                S_CORD: begin
                    r_cx <= n_cx;
                    r_cy <= n_cy;
                    r_cz <= n_cz;
                    if (r_i == LAST_STEP) r_state <= S_CFIN;
                    else r_i <= r_i + 1'b1;
                end
                S_CFIN: begin
                    if (r_vmode) begin
                        // magnitude gain correction on the shared multiplier
                        r_ua    <= r_cx;
                        r_ub    <= GAIN_Q16;
                        r_state <= S_MUL;
                    end else if (pc_last) begin
                        r_state <= S_OUT;
                    end else begin
                        r_pc    <= r_pc + 6'd1;
                        r_state <= S_ISSUE;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_o_x     <= r_x;
                        r_o_y     <= r_y;
                        r_o_hd    <= r_hd;
                        r_o_spd   <= r_spd;
                        r_o_tr    <= r_tr;
                        r_o_sail  <= r_sail;
                        r_o_sheet <= r_sheet;
                        r_ovalid  <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_cfg_ready     = 1'b1;
    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_ovalid;
    assign o_pos_x         = r_o_x;
    assign o_pos_y         = r_o_y;
    assign o_heading       = r_o_hd;
    assign o_speed         = r_o_spd;
    assign o_turn_rate     = r_o_tr;
    assign o_sail_position = r_o_sail;
    assign o_sheet_out     = r_o_sheet;

endmodule

[sv/sds_checker.sv]
`include "sailboat_dynamics_step_assert.svh"

module sds_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [31:0] o_pos_x
);

    // busy right after an input transfer
    `SDS_ASSERT_NEXT(a_busy_after_in, i_in_valid && o_in_ready, !o_in_ready)
    // a new result only comes out of a busy cycle
    `SDS_ASSERT_NOW(a_result_from_busy, $rose(o_out_valid), !$past(o_in_ready))
    // stalled result stays valid and unchanged
    `SDS_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)
    `SDS_ASSERT_NEXT(a_out_stable, o_out_valid && !i_out_ready, $stable(o_pos_x))
    // reset empties the output and frees the input
    `SDS_ASSERT_ALWAYS(a_reset_clears, !i_rst_n, !o_out_valid && o_in_ready)

endmodule

bind sailboat_dynamics_step sds_checker u_sds_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_ready (o_in_ready),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_pos_x    (o_pos_x)
);

[sim/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import sds_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int LONG_HOLD  = 3000;
    localparam longint HALF_PI = 102944;
    localparam longint PI_Q    = 205887;
    localparam longint TWO_PI  = 411775;

    typedef struct {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] heading;
        logic signed [31:0] speed;
        logic signed [31:0] turn_rate;
        logic signed [31:0] sail_position;
        logic signed [31:0] sheet_out;
    } t_boat_state;

    // Fixed-point boat model plus queue of predicted step results
    class boat_tracker;
        longint px, py, hdg, spd, turn, sheet, sail;
        longint sail_gain, rud_gain, drift_k, ang_drag, lin_drag, inv_inertia, inv_mass;
        longint effort_ofs;
        t_boat_state predicted_steps[$];
        int mismatches;
        int checked;

        function new();
            reset();
            mismatches = 0;
            checked = 0;
        endfunction

        function void reset();
            px = 0; py = 0; hdg = 0; spd = 0; turn = 0; sheet = 0; sail = 0;
            sail_gain = 65536; rud_gain = 65536; drift_k = 0; ang_drag = 0;
            lin_drag = 0; inv_inertia = 65536; inv_mass = 65536; effort_ofs = 0;
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint qadd(longint a, longint b);
            return clamp32(a + b);
        endfunction

        function longint qsub(longint a, longint b);
            return clamp32(a - b);
        endfunction

        function longint qmul(longint a, longint b);
            return clamp32((a * b) >>> 16);
        endfunction

        // Rotation-mode CORDIC after reduction into [-pi/2, pi/2]
        function void trig(longint a, output longint c, output longint s);
            longint r, x, y, z, dx, dy;
            bit flip;
            r = a % TWO_PI;
            x = longint'(GAIN_Q30);
            y = 0;
            flip = 0;
            if (r > PI_Q) r -= TWO_PI;
            else if (r < -PI_Q) r += TWO_PI;
            if (r > HALF_PI) begin
                r -= PI_Q; flip = 1;
            end else if (r < -HALF_PI) begin
                r += PI_Q; flip = 1;
            end
            z = r * 16384;
            for (int i = 0; i < 16; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= longint'(ATAN_Q30[i]);
                end else begin
                    x += dx; y -= dy; z += longint'(ATAN_Q30[i]);
                end
            end
            c = x >>> 14;
            s = y >>> 14;
            if (flip) begin
                c = -c; s = -s;
            end
        endfunction

        // Vectoring-mode CORDIC: direction and magnitude of (x, y)
        function void polar(longint xi, longint yi, output longint ang, output longint mag);
            longint x, y, z, dx, dy;
            x = xi; y = yi; z = 0;
            if (y == 0) begin
                ang = (x < 0) ? PI_Q : 0;
                mag = clamp32((x < 0) ? -x : x);
                return;
            end
            if (x < 0) begin
                z = ((y > 0) ? PI_Q : -PI_Q) * 16384;
                x = -x;
                y = -y;
            end
            for (int i = 0; i < 16; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x += dx; y -= dy; z += longint'(ATAN_Q30[i]);
                end else begin
                    x -= dx; y += dy; z -= longint'(ATAN_Q30[i]);
                end
            end
            ang = z >>> 14;
            mag = clamp32((x * longint'(GAIN_Q16)) >>> 16);
        endfunction

        function void write_reg(t_cfg_idx idx, logic [31:0] d);
            longint u;
            u = longint'(d[30:0]);
            case (idx)
                CFG_SAIL_LIFT_GAIN:     sail_gain = u;
                CFG_RUDDER_LIFT_GAIN:   rud_gain = u;
                CFG_DRIFT_GAIN:         drift_k = u;
                CFG_ANGULAR_DRAG:       ang_drag = u;
                CFG_LINEAR_DRAG:        lin_drag = u;
                CFG_INVERSE_INERTIA:    inv_inertia = u;
                CFG_INVERSE_MASS:       inv_mass = u;
                CFG_SAIL_EFFORT_OFFSET: effort_ofs = longint'($signed(d));
                default: ;
            endcase
        endfunction

        // One Euler step for an accepted input transfer
        function void note_step(longint rud, longint rate, longint ws, longint wd,
                                longint dt);
            longint rc, rs, awx, awy, awd, aws, ac, as_, shc, shs, hc, hs, wc, wsn;
            longint drift, dx, dy, rudc, ruds, fr, sdc, sds, sc, ss, fs, torque, thrust, v;
            longint f, nc, ns;
            t_boat_state e;
            if (sheet > -HALF_PI && sheet < HALF_PI)
                sheet = qadd(sheet, qmul(dt, rate));
            v = spd;
            trig(wd - hdg, rc, rs);
            awx = qsub(qmul(ws, rc), v);
            awy = qmul(ws, rs);
            polar(awx, awy, awd, aws);
            trig(awd, ac, as_);
            trig(sheet, shc, shs);
            if (ac + shc < 0) begin
                // tight sheet: sail follows the folded apparent wind
                f = awd;
                if (f > HALF_PI) f -= PI_Q;
                else if (f < -HALF_PI) f += PI_Q;
                sail = f;
                if (f == 0) sheet = 0;
            end else begin
                // loose sheet: leeward side, zero sine picks the negative side
                trig(-awd, nc, ns);
                sail = (ns > 0) ? sheet : clamp32(-sheet);
            end
            trig(hdg, hc, hs);
            trig(wd, wc, wsn);
            drift = qmul(drift_k, ws);
            dx = qadd(qmul(v, hc), qmul(drift, wc));
            dy = qadd(qmul(v, hs), qmul(drift, wsn));
            px = qadd(px, qmul(dx, dt));
            py = qadd(py, qmul(dy, dt));
            trig(rud, rudc, ruds);
            fr = qmul(qmul(rud_gain, v), ruds);
            trig(sail - awd, sdc, sds);
            fs = qmul(qmul(sail_gain, aws), sds);
            trig(sail, sc, ss);
            torque = qsub(qsub(qmul(qsub(effort_ofs, qmul(65536, sc)), fs),
                               qmul(qmul(131072, rudc), fr)),
                          qmul(qmul(ang_drag, turn), v));
            thrust = qsub(qsub(qmul(ss, fs), qmul(ruds, fr)), qmul(qmul(lin_drag, v), v));
            turn = qadd(turn, qmul(qmul(torque, inv_inertia), dt));
            spd = qadd(v, qmul(qmul(thrust, inv_mass), dt));
            hdg = qadd(hdg, qmul(turn, dt));
            e.pos_x = px[31:0]; e.pos_y = py[31:0]; e.heading = hdg[31:0];
            e.speed = spd[31:0]; e.turn_rate = turn[31:0];
            e.sail_position = sail[31:0]; e.sheet_out = sheet[31:0];
            predicted_steps.push_back(e);
        endfunction

        function void check_step(t_boat_state got);
            t_boat_state e;
            if (predicted_steps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("ERROR: result with no step pending");
                return;
            end
            e = predicted_steps.pop_front();
            checked++;
            if (got != e) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR step %0d: exp x=%0d y=%0d h=%0d v=%0d w=%0d sail=%0d sheet=%0d got x=%0d y=%0d h=%0d v=%0d w=%0d sail=%0d sheet=%0d",
                             checked, e.pos_x, e.pos_y, e.heading, e.speed, e.turn_rate,
                             e.sail_position, e.sheet_out, got.pos_x, got.pos_y,
                             got.heading, got.speed, got.turn_rate, got.sail_position,
                             got.sheet_out);
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [31:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic signed [17:0] i_rudder_angle = '0;
    logic signed [17:0] i_sheet_rate = '0;
    logic [30:0]        i_wind_speed = '0;
    logic signed [19:0] i_wind_heading = '0;
    logic [16:0]        i_step_length = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [31:0] o_pos_x, o_pos_y, o_heading, o_speed, o_turn_rate;
    logic signed [31:0] o_sail_position, o_sheet_out;

    boat_tracker tracker = new();
    int  items_sent = 0;
    int  cfg_writes = 0;
    int  burst_left = 0;
    int  idle_cycles = 0;
    bit  hold_request = 0;
    bit  long_hold_seen = 0;

    sailboat_dynamics_step uut (.*);

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Receiver: changing stall patterns, plus one long hold-off on request
    initial begin
        int mode;
        mode = 0;
        forever begin
            if (hold_request) begin
                i_out_ready <= 1'b0;
                for (int k = 0; k < LONG_HOLD; k++) @(posedge i_clk);
                hold_request = 0;
                long_hold_seen = 1;
            end else begin
                if ($urandom_range(63) == 0) mode = $urandom_range(2);
                case (mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= $urandom_range(1);
                    default: i_out_ready <= ($urandom_range(3) == 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    // Result check and watchdog, sampled mid-cycle ahead of the transfer edge
    always @(negedge i_clk) begin
        t_boat_state got;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got.pos_x = o_pos_x; got.pos_y = o_pos_y; got.heading = o_heading;
                got.speed = o_speed; got.turn_rate = o_turn_rate;
                got.sail_position = o_sail_position; got.sheet_out = o_sheet_out;
                tracker.check_step(got);
            end
            if ((o_out_valid && i_out_ready) || (i_in_valid && o_in_ready) ||
                (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("ERROR: no transfer for %0d cycles", IDLE_LIMIT);
                $display("FAIL sailboat_dynamics_step");
                $finish;
            end
        end
    end

    // Valid stays up between back-to-back writes; the caller drops it
    task automatic write_reg(t_cfg_idx idx, logic [31:0] d);
        bit got;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do begin
            @(negedge i_clk);
            got = o_cfg_ready;
            @(posedge i_clk);
        end while (!got);
        tracker.write_reg(idx, d);
        cfg_writes++;
    endtask

    task automatic send_step(logic [17:0] rud, logic [17:0] rate, logic [30:0] ws,
                             logic [19:0] wd, logic [16:0] dt);
        bit got;
        // sender bursts with random gaps between them
        if (burst_left == 0) begin
            int gap;
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(40);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        i_in_valid     <= 1'b1;
        i_rudder_angle <= rud;
        i_sheet_rate   <= rate;
        i_wind_speed   <= ws;
        i_wind_heading <= wd;
        i_step_length  <= dt;
        do begin
            @(negedge i_clk);
            got = o_in_ready;
            @(posedge i_clk);
        end while (!got);
        tracker.note_step(longint'($signed(rud)), longint'($signed(rate)),
                          longint'(ws), longint'($signed(wd)), longint'(dt));
        items_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (tracker.predicted_steps.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // Random step: mostly in range, some raw full-width fields
    task automatic random_step();
        logic [17:0] rud, rate;
        logic [30:0] ws;
        logic [19:0] wd;
        logic [16:0] dt;
        if ($urandom_range(9) == 0) begin
            rud  = 18'($urandom);
            rate = 18'($urandom);
            ws   = 31'($urandom);
            wd   = 20'($urandom);
            dt   = 17'($urandom);
        end else begin
            rud  = 18'($signed($urandom_range(205888)) - 102944);
            rate = 18'($signed($urandom_range(131072)) - 65536);
            case ($urandom_range(3))
                0: ws = 31'($urandom);
                1: ws = 31'($urandom_range(65536 * 64));
                default: ws = 31'($urandom_range(65536 * 8));
            endcase
            wd = 20'($signed($urandom_range(823550)) - 411775);
            dt = ($urandom_range(7) == 0) ? 17'd65536 : 17'($urandom_range(16384));
        end
        send_step(rud, rate, ws, wd, dt);
    endtask

    task automatic load_settings(int kind);
        for (int r = 0; r < 8; r++) begin
            logic [31:0] d;
            case (kind)
                0: d = (r == 2 || r == 3 || r == 4 || r == 7) ? 32'd0 : 32'd65536;
                1: d = (r == 7) ? 32'h7FFFFFFF : 32'h7FFFFFFF;
                2: d = (r == 7) ? 32'h80000000 : 32'd0;
                3: d = (r == 7) ? 32'($signed($urandom_range(262144)) - 131072)
                                : 32'($urandom_range(131072));
                default: d = $urandom;
            endcase
            write_reg(t_cfg_idx'(r), d);
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, zero and reversed wind, loose and tight sheet
        send_step(18'd0, 18'd0, 31'd0, 20'd0, 17'd65536);
        send_step(18'd0, 18'd65536, 31'd65536, 20'd0, 17'd65536);
        send_step(18'd102944, 18'd65536, 31'd131072, 20'd205887, 17'd65536);
        send_step(-18'sd102944, -18'sd65536, 31'd131072, -20'sd205887, 17'd65536);
        send_step(18'd102944, 18'd65536, 31'h7FFFFFFF, 20'd411775, 17'd65536);
        send_step(-18'sd102944, 18'd65536, 31'h7FFFFFFF, -20'sd411775, 17'd0);
        send_step(18'h1FFFF, 18'h1FFFF, 31'h7FFFFFFF, 20'h7FFFF, 17'h1FFFF);
        send_step(18'h20000, 18'h20000, 31'd1, 20'h80000, 17'h1FFFF);
        send_step(18'd0, 18'd65536, 31'd65536, 20'd102944, 17'd65536);
        send_step(18'd0, -18'sd65536, 31'd65536, -20'sd102944, 17'd65536);
        send_step(18'd51472, 18'd0, 31'd327680, 20'd0, 17'd32768);
        send_step(18'd0, 18'd0, 31'd0, 20'd0, 17'd0);
        send_step(-18'sd51472, 18'd65536, 31'd65536, 20'd205887, 17'd65536);
        send_step(18'd0, 18'd65536, 31'd655360, 20'd51472, 17'd65536);
        send_step(18'd0, 18'd65536, 31'd655360, -20'sd51472, 17'd65536);
        drain();

        // phases over several register settings, extremes among them
        for (int ph = 0; ph < 6; ph++) begin
            load_settings(ph == 5 ? 4 : ph);
            for (int n = 0; n < 220; n++) begin
                if (ph == 1 && n == 20) hold_request = 1;
                if (n == 110) drain();
                random_step();
            end
            drain();
        end

        repeat (500) @(posedge i_clk);
        $display("Covered %0d steps over %0d register writes, %0d results checked.",
                 items_sent, cfg_writes, tracker.checked);
        $display("Receiver long hold-off exercised: %0d", long_hold_seen);
        if (tracker.mismatches == 0 && tracker.predicted_steps.size() == 0)
            $display("PASS sailboat_dynamics_step");
        else
            $display("FAIL sailboat_dynamics_step");
        $finish;
    end

endmodule

[files.f]
+incdir+sv
sv/sds_pkg.sv
sv/sailboat_dynamics_step.sv
sv/sds_checker.sv
sim/testbench.sv
